>>> sv/psd_pkg.sv
// Shared constants and types for the point to segment squared distance block.
// No dependencies.
package psd_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int DIST_BITS      = 49;
	localparam int FIFO_DEPTH     = 4;

	typedef logic [1:0] region_t;

	localparam region_t REGION_START    = 2'd0;
	localparam region_t REGION_INTERIOR = 2'd1;
	localparam region_t REGION_END      = 2'd2;

endpackage

>>> sv/psd_front.sv
// Front end: coordinate differences, dot and squared length, region classification.
// Uses psd_pkg. Feeds the word queue in front of psd_back.
module psd_front #(
	parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_BITS-1:0]  point_x,
	input  logic signed [COORD_BITS-1:0]  point_y,
	input  logic signed [COORD_BITS-1:0]  start_x,
	input  logic signed [COORD_BITS-1:0]  start_y,
	input  logic signed [COORD_BITS-1:0]  end_x,
	input  logic signed [COORD_BITS-1:0]  end_y,
	input  logic                          q_full,
	output logic                          q_push,
	output logic signed [COORD_BITS:0]    f_a,
	output logic signed [COORD_BITS:0]    f_b,
	output logic signed [COORD_BITS:0]    f_c,
	output logic signed [COORD_BITS:0]    f_d,
	output logic [2*COORD_BITS+1:0]       f_rem,
	output logic [2*COORD_BITS+1:0]       f_len,
	output psd_pkg::region_t              f_region,
	output logic                          f_full
);

	localparam int AW = COORD_BITS + 1;
	localparam int PW = 2 * COORD_BITS + 2;

	logic fe;

	logic                 v_s1, v_s2, v_s3;
	logic signed [AW-1:0] a_s1, b_s1, c_s1, d_s1;
	logic signed [AW-1:0] a_s2, b_s2, c_s2, d_s2;
	logic signed [PW-1:0] ac_s2, bd_s2, cc_s2, dd_s2;
	logic signed [AW-1:0] a_s3, b_s3, c_s3, d_s3;
	logic signed [PW:0]   dot_s3;
	logic [PW-1:0]        len_s3;

	logic dot_neg, len_zero, dot_gt;

	assign fe       = !q_full;
	assign in_stall = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (fe) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			a_s1 <= AW'(point_x) - AW'(start_x);
			b_s1 <= AW'(point_y) - AW'(start_y);
			c_s1 <= AW'(end_x) - AW'(start_x);
			d_s1 <= AW'(end_y) - AW'(start_y);

			ac_s2 <= a_s1 * c_s1;
			bd_s2 <= b_s1 * d_s1;
			cc_s2 <= c_s1 * c_s1;
			dd_s2 <= d_s1 * d_s1;
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			c_s2  <= c_s1;
			d_s2  <= d_s1;

			dot_s3 <= (PW + 1)'(ac_s2) + (PW + 1)'(bd_s2);
			len_s3 <= cc_s2[PW-1:0] + dd_s2[PW-1:0];
			a_s3   <= a_s2;
			b_s3   <= b_s2;
			c_s3   <= c_s2;
			d_s3   <= d_s2;
		end
	end

	assign dot_neg  = dot_s3[PW];
	assign len_zero = (len_s3 == '0);
	assign dot_gt   = !dot_neg && (dot_s3[PW-1:0] > len_s3);

	always_comb begin
		if (len_zero || dot_neg) begin
			f_region = psd_pkg::REGION_START;
		end else if (dot_gt) begin
			f_region = psd_pkg::REGION_END;
		end else begin
			f_region = psd_pkg::REGION_INTERIOR;
		end
	end

	assign f_full = (dot_s3[PW-1:0] == len_s3);
	assign f_rem  = dot_s3[PW-1:0];
	assign f_len  = len_s3;
	assign f_a    = a_s3;
	assign f_b    = b_s3;
	assign f_c    = c_s3;
	assign f_d    = d_s3;
	assign q_push = fe && v_s3;

endmodule

>>> sv/psd_fifo.sv
// Small word queue between front and back ends, register array storage.
// Uses psd_pkg for nothing beyond the default depth handed in by the top level.
module psd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = psd_pkg::FIFO_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTRW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/psd_back.sv
// Back end: pipelined restoring divider for the projection, foot point offset,
// split squaring and the saturating output register. Uses psd_pkg.
module psd_back #(
	parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = psd_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	output logic                              q_pop,
	input  logic signed [COORD_BITS:0]        q_a,
	input  logic signed [COORD_BITS:0]        q_b,
	input  logic signed [COORD_BITS:0]        q_c,
	input  logic signed [COORD_BITS:0]        q_d,
	input  logic [2*COORD_BITS+1:0]           q_rem,
	input  logic [2*COORD_BITS+1:0]           q_len,
	input  psd_pkg::region_t                  q_region,
	input  logic                              q_full,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [psd_pkg::DIST_BITS-1:0]     dist_sq,
	output psd_pkg::region_t                  region
);

	localparam int AW    = COORD_BITS + 1;
	localparam int LW    = 2 * COORD_BITS + 2;
	localparam int F     = FRAC_BITS;
	localparam int DW    = COORD_BITS + FRAC_BITS + 3;
	localparam int K     = (DW + 1) / 2;
	localparam int HW    = DW - K;
	localparam int SUMW  = 2 * DW + 1;
	localparam int SHW   = SUMW - F;
	localparam int DB    = psd_pkg::DIST_BITS;
	localparam int EXW   = (SHW > DB) ? SHW : DB + 1;
	localparam logic [F:0] T_ONE = {1'b1, {F{1'b0}}};

	logic be;

	// divider stages
	logic [F-1:0]         vd_q;
	logic [LW-1:0]        rem_s [F];
	logic [F-1:0]         tq_s  [F];
	logic [LW-1:0]        len_s [F];
	logic signed [AW-1:0] a_s   [F];
	logic signed [AW-1:0] b_s   [F];
	logic signed [AW-1:0] c_s   [F];
	logic signed [AW-1:0] d_s   [F];
	psd_pkg::region_t     rg_s  [F];
	logic                 fl_s  [F];

	assign be    = !out_valid || !out_stall;
	assign q_pop = be && !q_empty;

	for (genvar k = 0; k < F; k++) begin : g_div
		logic                 v_in;
		logic [LW-1:0]        rem_in, len_in;
		logic [F-1:0]         tq_in;
		logic signed [AW-1:0] a_in, b_in, c_in, d_in;
		psd_pkg::region_t     rg_in;
		logic                 fl_in;
		logic [LW:0]          rem2, diff;
		logic                 ge;

		if (k == 0) begin : g_first
			assign v_in   = q_pop;
			assign rem_in = q_rem;
			assign len_in = q_len;
			assign tq_in  = '0;
			assign a_in   = q_a;
			assign b_in   = q_b;
			assign c_in   = q_c;
			assign d_in   = q_d;
			assign rg_in  = q_region;
			assign fl_in  = q_full;
		end else begin : g_next
			assign v_in   = vd_q[k-1];
			assign rem_in = rem_s[k-1];
			assign len_in = len_s[k-1];
			assign tq_in  = tq_s[k-1];
			assign a_in   = a_s[k-1];
			assign b_in   = b_s[k-1];
			assign c_in   = c_s[k-1];
			assign d_in   = d_s[k-1];
			assign rg_in  = rg_s[k-1];
			assign fl_in  = fl_s[k-1];
		end

		assign rem2 = {rem_in, 1'b0};
		assign ge   = (rem2 >= {1'b0, len_in});
		assign diff = rem2 - {1'b0, len_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd_q[k] <= 1'b0;
			end else if (be) begin
				vd_q[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (be) begin
				rem_s[k] <= ge ? diff[LW-1:0] : rem2[LW-1:0];
				tq_s[k]  <= {tq_in[F-2:0], ge};
				len_s[k] <= len_in;
				a_s[k]   <= a_in;
				b_s[k]   <= b_in;
				c_s[k]   <= c_in;
				d_s[k]   <= d_in;
				rg_s[k]  <= rg_in;
				fl_s[k]  <= fl_in;
			end
		end
	end

	// distance stages
	logic [F:0]           t_sel;
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	psd_pkg::region_t     rg_s1, rg_s2, rg_s3, rg_s4, rg_s5;
	logic signed [DW-1:0] as_s1, bs_s1, tc_s1, td_s1;
	logic signed [DW-1:0] dx_s2, dy_s2;
	logic [DW-1:0]        mx_s3, my_s3;
	logic [2*HW-1:0]      hhx_s4, hhy_s4;
	logic [DW-1:0]        hlx_s4, hly_s4;
	logic [2*K-1:0]       llx_s4, lly_s4;
	logic [2*DW-1:0]      sqx_s5, sqy_s5;
	logic [SUMW-1:0]      sum;
	logic [EXW-1:0]       shifted;

	logic                 out_v_q;
	logic [DB-1:0]        dist_q;
	psd_pkg::region_t     region_q;

	always_comb begin
		if (rg_s[F-1] == psd_pkg::REGION_START) begin
			t_sel = '0;
		end else if (rg_s[F-1] == psd_pkg::REGION_END || fl_s[F-1]) begin
			t_sel = T_ONE;
		end else begin
			t_sel = {1'b0, tq_s[F-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (be) begin
			v_s1    <= vd_q[F-1];
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			out_v_q <= v_s5;
		end
	end

	assign sum     = {1'b0, sqx_s5} + {1'b0, sqy_s5};
	assign shifted = EXW'(sum >> F);

	always_ff @(posedge clk) begin
		if (be) begin
			tc_s1 <= $signed({1'b0, t_sel}) * c_s[F-1];
			td_s1 <= $signed({1'b0, t_sel}) * d_s[F-1];
			as_s1 <= DW'(a_s[F-1]) <<< F;
			bs_s1 <= DW'(b_s[F-1]) <<< F;
			rg_s1 <= rg_s[F-1];

			dx_s2 <= as_s1 - tc_s1;
			dy_s2 <= bs_s1 - td_s1;
			rg_s2 <= rg_s1;

			mx_s3 <= dx_s2[DW-1] ? -dx_s2 : dx_s2;
			my_s3 <= dy_s2[DW-1] ? -dy_s2 : dy_s2;
			rg_s3 <= rg_s2;

			hhx_s4 <= mx_s3[DW-1:K] * mx_s3[DW-1:K];
			hlx_s4 <= mx_s3[DW-1:K] * mx_s3[K-1:0];
			llx_s4 <= mx_s3[K-1:0] * mx_s3[K-1:0];
			hhy_s4 <= my_s3[DW-1:K] * my_s3[DW-1:K];
			hly_s4 <= my_s3[DW-1:K] * my_s3[K-1:0];
			lly_s4 <= my_s3[K-1:0] * my_s3[K-1:0];
			rg_s4  <= rg_s3;

			sqx_s5 <= ((2 * DW)'(hhx_s4) << (2 * K)) + ((2 * DW)'(hlx_s4) << (K + 1))
				+ (2 * DW)'(llx_s4);
			sqy_s5 <= ((2 * DW)'(hhy_s4) << (2 * K)) + ((2 * DW)'(hly_s4) << (K + 1))
				+ (2 * DW)'(lly_s4);
			rg_s5  <= rg_s4;

			dist_q   <= (|shifted[EXW-1:DB]) ? {DB{1'b1}} : shifted[DB-1:0];
			region_q <= rg_s5;
		end
	end

	assign out_valid = out_v_q;
	assign dist_sq   = dist_q;
	assign region    = region_q;

endmodule

>>> sv/point_segment_distance_sq_top.sv
// Squared distance from a query point to a segment, one word in and one word out per cycle
// while neither in_stall nor out_stall holds the flow. An input word is taken every cycle in
// which the front end's queue has room; the result passes through the front end stages, the
// queue, the one bit per stage projection divider (FRAC_BITS stages) and the squaring stages.
// dist_sq carries FRAC_BITS fraction bits and saturates at its all-ones value; region is 0
// when the projection falls before the start point or the segment has zero length, 1 when it
// falls on the segment, both end points included, and 2 when it falls past the end point.
// Depends on psd_pkg, psd_front, psd_fifo and psd_back.
module point_segment_distance_sq_top #(
	parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = psd_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_BITS-1:0]  point_x,
	input  logic signed [COORD_BITS-1:0]  point_y,
	input  logic signed [COORD_BITS-1:0]  start_x,
	input  logic signed [COORD_BITS-1:0]  start_y,
	input  logic signed [COORD_BITS-1:0]  end_x,
	input  logic signed [COORD_BITS-1:0]  end_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [psd_pkg::DIST_BITS-1:0] dist_sq,
	output logic [1:0]                    region
);

	localparam int AW = COORD_BITS + 1;
	localparam int LW = 2 * COORD_BITS + 2;
	localparam int EW = 4 * AW + 2 * LW + 3;

	logic                 q_push, q_pop, q_full, q_empty;
	logic [EW-1:0]        q_wdata, q_rdata;

	logic signed [AW-1:0] f_a, f_b, f_c, f_d;
	logic [LW-1:0]        f_rem, f_len;
	psd_pkg::region_t     f_region;
	logic                 f_full;

	logic signed [AW-1:0] b_a, b_b, b_c, b_d;
	logic [LW-1:0]        b_rem, b_len;
	psd_pkg::region_t     b_region;
	logic                 b_full;

	psd_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.point_x  (point_x),
		.point_y  (point_y),
		.start_x  (start_x),
		.start_y  (start_y),
		.end_x    (end_x),
		.end_y    (end_y),
		.q_full   (q_full),
		.q_push   (q_push),
		.f_a      (f_a),
		.f_b      (f_b),
		.f_c      (f_c),
		.f_d      (f_d),
		.f_rem    (f_rem),
		.f_len    (f_len),
		.f_region (f_region),
		.f_full   (f_full)
	);

	assign q_wdata = {f_a, f_b, f_c, f_d, f_rem, f_len, f_region, f_full};

	psd_fifo #(
		.WIDTH(EW),
		.DEPTH(psd_pkg::FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign {b_a, b_b, b_c, b_d, b_rem, b_len, b_region, b_full} = q_rdata;

	psd_back #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_a       (b_a),
		.q_b       (b_b),
		.q_c       (b_c),
		.q_d       (b_d),
		.q_rem     (b_rem),
		.q_len     (b_len),
		.q_region  (b_region),
		.q_full    (b_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dist_sq   (dist_sq),
		.region    (region)
	);

endmodule
